[rtl/tgadec_pkg.sv]
`default_nettype none

package tgadec_pkg;

    // Supported pixel depths in bits
    localparam logic [7:0] DEPTH_8  = 8'd8;
    localparam logic [7:0] DEPTH_16 = 8'd16;
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    // Result kinds
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    // Command queue between parser and pixel formatter
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // One classified result, as the parser hands it to the formatter
    typedef struct packed {
        logic        kind;
        logic        format_error;
        logic        last_pixel;
        logic [7:0]  repeat_res;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  lastb;
        logic [7:0]  depth;
        logic [15:0] width;
        logic [15:0] height;
    } cmd_t;

    // Queue occupancy seen by both sides
    typedef struct packed {
        logic full;
        logic avail;
    } q_status_t;

endpackage

`default_nettype wire

[rtl/tgadec_if.sv]
`default_nettype none

// Byte stream of the TGA file
interface tgadec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

// Header and pixel results
interface tgadec_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_res;
    logic        last_pixel;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  bits_per_pixel;
    logic        format_error;

    modport source (output valid, output kind, output red, output green, output blue,
                    output alpha, output repeat_res, output last_pixel,
                    output image_width, output image_height, output bits_per_pixel,
                    output format_error, input ready);
    modport sink   (input valid, input kind, input red, input green, input blue,
                    input alpha, input repeat_res, input last_pixel,
                    input image_width, input image_height, input bits_per_pixel,
                    input format_error, output ready);
endinterface

// Channel count register write
interface tgadec_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] desired_channels;

    modport source (output valid, output desired_channels, input ready);
    modport sink   (input valid, input desired_channels, output ready);
endinterface

`default_nettype wire

[rtl/tgadec_front.sv]
`default_nettype none

module tgadec_front #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    tgadec_in_if.sink                  stream,
    input  wire tgadec_pkg::q_status_t q_stat,
    output logic                       push,
    output tgadec_pkg::cmd_t           cmd
);
    import tgadec_pkg::*;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_PACKET = 2'd1;
    localparam logic [1:0] PH_PIXEL  = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam logic [4:0] POS_TYPE     = 5'd2;
    localparam logic [4:0] POS_WIDTH_LO = 5'd12;
    localparam logic [4:0] POS_WIDTH_HI = 5'd13;
    localparam logic [4:0] POS_HEIGHT_LO = 5'd14;
    localparam logic [4:0] POS_HEIGHT_HI = 5'd15;
    localparam logic [4:0] POS_DEPTH    = 5'd16;
    localparam logic [4:0] POS_LAST     = 5'd17;

    localparam logic [7:0] TYPE_RLE_RGB = 8'd10;
    localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

    logic [1:0]            phase_reg, phase_next;
    logic [4:0]            pos_reg, pos_next;
    logic [7:0]            type_reg, type_next;
    logic [15:0]           width_reg, width_next;
    logic [15:0]           height_reg, height_next;
    logic [7:0]            depth_reg, depth_next;
    logic                  run_reg, run_next;
    logic [6:0]            pkt_left_reg, pkt_left_next;
    logic [1:0]            idx_reg, idx_next;
    logic [7:0]            pb0_reg, pb0_next;
    logic [7:0]            pb1_reg, pb1_next;
    logic [7:0]            pb2_reg, pb2_next;
    logic [COUNT_BITS-1:0] left_reg, left_next;
    logic [31:0]           prod_reg;

    logic                  fire;
    logic [1:0]            ph;
    logic [4:0]            pos;
    logic                  prod_load;
    logic                  depth_ok;
    logic [COUNT_BITS-1:0] count;
    logic [2:0]            nbytes;
    logic [7:0]            want;
    logic [7:0]            rep;
    logic [COUNT_BITS-1:0] rep_ext;
    logic                  is_rle;

    assign stream.ready = !q_stat.full;
    assign fire         = stream.valid && !q_stat.full;

    // A first-byte mark restarts the header
    assign ph  = stream.first_byte ? PH_HEADER : phase_reg;
    assign pos = stream.first_byte ? '0 : pos_reg;

    assign prod_load = fire && (ph == PH_HEADER) && (pos == POS_DEPTH);
    assign depth_ok  = (depth_reg == DEPTH_8) || (depth_reg == DEPTH_16) ||
                       (depth_reg == DEPTH_24) || (depth_reg == DEPTH_32);
    assign count     = ({1'b0, prod_reg} > CNT_MAX) ? '1 : prod_reg[COUNT_BITS-1:0];
    assign nbytes    = depth_reg[5:3];
    assign is_rle    = (type_reg == TYPE_RLE_RGB);
    assign want      = {1'b0, pkt_left_reg} + 8'd1;

    // Clamp a run to the pixels that remain
    always_comb
    begin
        if (is_rle && run_reg)
        begin
            if ({{(COUNT_BITS-8){1'b0}}, want} > left_reg)
                rep = left_reg[7:0];
            else
                rep = want;
        end
        else
        begin
            rep = 8'd1;
        end
    end
    assign rep_ext = {{(COUNT_BITS-8){1'b0}}, rep};

    // Parse one byte
    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        type_next     = type_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        depth_next    = depth_reg;
        run_next      = run_reg;
        pkt_left_next = pkt_left_reg;
        idx_next      = idx_reg;
        pb0_next      = pb0_reg;
        pb1_next      = pb1_reg;
        pb2_next      = pb2_reg;
        left_next     = left_reg;
        push          = 1'b0;

        cmd              = '0;
        cmd.b0           = pb0_reg;
        cmd.b1           = pb1_reg;
        cmd.b2           = pb2_reg;
        cmd.lastb        = stream.data_byte;
        cmd.depth        = depth_reg;
        cmd.width        = width_reg;
        cmd.height       = height_reg;

        if (fire)
        begin
            case (ph)
                PH_HEADER:
                begin
                    case (pos)
                        POS_TYPE:      type_next = stream.data_byte;
                        POS_WIDTH_LO:  width_next[7:0] = stream.data_byte;
                        POS_WIDTH_HI:  width_next[15:8] = stream.data_byte;
                        POS_HEIGHT_LO: height_next[7:0] = stream.data_byte;
                        POS_HEIGHT_HI: height_next[15:8] = stream.data_byte;
                        POS_DEPTH:     depth_next = stream.data_byte;
                        default:       ;
                    endcase
                    if (pos != POS_LAST)
                    begin
                        pos_next   = pos + 5'd1;
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        // Header complete: set up the pixel count and report
                        pos_next      = '0;
                        left_next     = count;
                        run_next      = 1'b0;
                        pkt_left_next = '0;
                        idx_next      = '0;
                        if (!depth_ok || (count == '0))
                            phase_next = PH_DONE;
                        else if (is_rle)
                            phase_next = PH_PACKET;
                        else
                            phase_next = PH_PIXEL;
                        push             = 1'b1;
                        cmd.kind         = KIND_HEADER;
                        cmd.format_error = !depth_ok;
                        cmd.last_pixel   = !depth_ok || (count == '0);
                        cmd.lastb        = '0;
                        cmd.b0           = '0;
                        cmd.b1           = '0;
                        cmd.b2           = '0;
                    end
                end
                PH_PACKET:
                begin
                    run_next      = stream.data_byte[7];
                    pkt_left_next = stream.data_byte[6:0];
                    idx_next      = '0;
                    phase_next    = PH_PIXEL;
                end
                PH_PIXEL:
                begin
                    if ({1'b0, idx_reg} + 3'd1 < nbytes)
                    begin
                        // Gather a leading byte of the pixel
                        case (idx_reg)
                            2'd0:    pb0_next = stream.data_byte;
                            2'd1:    pb1_next = stream.data_byte;
                            default: pb2_next = stream.data_byte;
                        endcase
                        idx_next = idx_reg + 2'd1;
                    end
                    else
                    begin
                        left_next      = left_reg - rep_ext;
                        idx_next       = '0;
                        push           = 1'b1;
                        cmd.kind       = KIND_PIXEL;
                        cmd.repeat_res = rep;
                        cmd.last_pixel = (left_reg == rep_ext);
                        if (is_rle && run_reg)
                            pkt_left_next = '0;
                        if (left_reg == rep_ext)
                            phase_next = PH_DONE;
                        else if (is_rle)
                        begin
                            if (run_reg || (pkt_left_reg == '0))
                                phase_next = PH_PACKET;
                            else
                                pkt_left_next = pkt_left_reg - 7'd1;
                        end
                    end
                end
                default:
                begin
                    // Trailing bytes: drop
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            pos_reg      <= '0;
            type_reg     <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            depth_reg    <= '0;
            run_reg      <= 1'b0;
            pkt_left_reg <= '0;
            idx_reg      <= '0;
            left_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            type_reg     <= type_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            depth_reg    <= depth_next;
            run_reg      <= run_next;
            pkt_left_reg <= pkt_left_next;
            idx_reg      <= idx_next;
            left_reg     <= left_next;
        end
    end

    // Pixel bytes and the header product need no reset
    always_ff @(posedge clk)
    begin
        pb0_reg <= pb0_next;
        pb1_reg <= pb1_next;
        pb2_reg <= pb2_next;
        if (prod_load)
            prod_reg <= width_reg * height_reg;
    end

endmodule

`default_nettype wire

[rtl/tgadec_queue.sv]
`default_nettype none

module tgadec_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire tgadec_pkg::cmd_t      push_cmd,
    input  wire logic                  pop,
    output tgadec_pkg::cmd_t           head,
    output tgadec_pkg::q_status_t      q_stat
);
    import tgadec_pkg::*;

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign q_stat.full  = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign q_stat.avail = (count_reg != '0);
    assign head         = entry_reg[rd_ptr_reg];

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && q_stat.avail;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

[rtl/tgadec_back.sv]
`default_nettype none

module tgadec_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tgadec_pkg::q_status_t q_stat,
    input  wire tgadec_pkg::cmd_t      head,
    output logic                       pop,
    tgadec_cfg_if.sink                 cfg,
    tgadec_out_if.source               pix
);
    import tgadec_pkg::*;

    localparam logic [2:0] CH_RGB   = 3'd3;
    localparam logic [2:0] CH_RESET = 3'd4;

    logic [2:0]  chan_reg;
    logic        valid_reg;
    logic        kind_reg;
    logic [7:0]  red_reg, green_reg, blue_reg, alpha_reg;
    logic [7:0]  rep_reg;
    logic        last_reg;
    logic [15:0] width_reg, height_reg;
    logic [7:0]  depth_reg;
    logic        err_reg;

    logic [7:0]  red_next, green_next, blue_next, alpha_next;
    logic [15:0] word;

    assign cfg.ready = 1'b1;
    assign pop       = q_stat.avail && (!valid_reg || pix.ready);
    assign word      = {head.lastb, head.b0};

    // Convert the gathered pixel bytes to RGBA
    always_comb
    begin
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        alpha_next = '0;
        if (head.kind == KIND_PIXEL)
        begin
            case (head.depth)
                DEPTH_8:
                begin
                    red_next   = head.lastb;
                    green_next = head.lastb;
                    blue_next  = head.lastb;
                    alpha_next = 8'hFF;
                end
                DEPTH_16:
                begin
                    red_next   = {word[14:10], 3'b000};
                    green_next = {word[9:5], 3'b000};
                    blue_next  = {word[4:0], 3'b000};
                    alpha_next = word[15] ? 8'hFF : 8'h00;
                end
                DEPTH_24:
                begin
                    red_next   = head.lastb;
                    green_next = head.b1;
                    blue_next  = head.b0;
                    alpha_next = 8'hFF;
                end
                default:
                begin
                    red_next   = head.b2;
                    green_next = head.b1;
                    blue_next  = head.b0;
                    alpha_next = head.lastb;
                end
            endcase
            if (chan_reg == CH_RGB)
                alpha_next = '0;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg  <= CH_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                chan_reg <= cfg.desired_channels;
            if (pop)
                valid_reg <= 1'b1;
            else if (pix.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg   <= head.kind;
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            alpha_reg  <= alpha_next;
            rep_reg    <= head.repeat_res;
            last_reg   <= head.last_pixel;
            width_reg  <= head.width;
            height_reg <= head.height;
            depth_reg  <= head.depth;
            err_reg    <= head.format_error;
        end
    end

    assign pix.valid          = valid_reg;
    assign pix.kind           = kind_reg;
    assign pix.red            = red_reg;
    assign pix.green          = green_reg;
    assign pix.blue           = blue_reg;
    assign pix.alpha          = alpha_reg;
    assign pix.repeat_res     = rep_reg;
    assign pix.last_pixel     = last_reg;
    assign pix.image_width    = width_reg;
    assign pix.image_height   = height_reg;
    assign pix.bits_per_pixel = depth_reg;
    assign pix.format_error   = err_reg;

endmodule

`default_nettype wire

[rtl/tga_rle_pixel_decoder_top.sv]
// TGA decoder: takes a TGA file one byte per transaction on byte_stream
// (first_byte marks the first byte of a new file) and returns results on
// pixel_stream. After the 18-byte header one header result (kind 0) gives
// width, height, depth and a format error flag. Then each pixel, or each
// RLE run with its repeat count, gives one pixel result (kind 1).
// cfg writes the output channel count (3: RGB, alpha 0; else RGBA); write
// it only while no transaction is in flight.
// Throughput: while pixel_stream.ready is high, the byte parser takes one
// byte per cycle sustained and the pixel formatter one result per cycle.
// A result completed by a byte passes from the parser into a two-entry
// queue, then into the formatter's output register, and appears on
// pixel_stream from there.
// Reset: parser waits for header byte 0, channel count is 4, queue and
// output register are empty.
// Stall: a held result stays in the output register; the queue absorbs two
// more results, after which byte_stream.ready drops until space returns.
`default_nettype none

module tga_rle_pixel_decoder_top #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tgadec_in_if.sink    byte_stream,
    tgadec_cfg_if.sink   cfg,
    tgadec_out_if.source pixel_stream
);
    import tgadec_pkg::*;

    cmd_t      push_cmd;
    cmd_t      head;
    logic      push;
    logic      pop;
    q_status_t q_stat;

    tgadec_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (byte_stream),
        .q_stat (q_stat),
        .push   (push),
        .cmd    (push_cmd)
    );

    tgadec_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    tgadec_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .head   (head),
        .pop    (pop),
        .cfg    (cfg),
        .pix    (pixel_stream)
    );

`ifndef SYNTH
    // Parser never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("command pushed into full queue");

    // A depth error ends the image in the header result
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_stream.valid && pixel_stream.format_error) |->
            (pixel_stream.last_pixel && (pixel_stream.kind == KIND_HEADER)))
        else $error("format error without end of image");

    // Pixel results carry a nonzero repeat count
    a_pix_rep: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_stream.valid && (pixel_stream.kind == KIND_PIXEL)) |->
            (pixel_stream.repeat_res != 8'd0))
        else $error("pixel result with zero repeat count");
`endif

endmodule

`default_nettype wire
